[hdl/lelt_pkg.sv]
// Shared constants, codes and index helpers for the lower envelope line table.
package lelt_pkg;

    // Store geometry.
    localparam int MAX_LINES = 1024;
    localparam int IDX_W     = $clog2(MAX_LINES);
    localparam int CNT_W     = $clog2(MAX_LINES + 1);
    localparam int SUM_W     = CNT_W + 1;
    localparam int SRCH_W    = CNT_W + 1;

    // Field and datapath widths.
    localparam int KIND_W    = 3;
    localparam int IN_W      = 32;
    localparam int COEF_W    = IN_W + 1;
    localparam int LINE_W    = 2 * COEF_W;
    localparam int DIFF_W    = COEF_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int VALUE_W   = 64;
    localparam int STATUS_W  = 2;
    localparam int LCOUNT_W  = 11;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INC    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DEC    = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ORDER = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

    // Physical slot of the line at position off from the head.
    function automatic logic [IDX_W-1:0] slot_idx(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(off);
        if (sum >= SUM_W'(MAX_LINES)) begin
            sum = sum - SUM_W'(MAX_LINES);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Circular increment of a slot index.
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(MAX_LINES - 1)) ? '0 : idx + 1'b1;
    endfunction

    // Circular decrement of a slot index.
    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? IDX_W'(MAX_LINES - 1) : idx - 1'b1;
    endfunction

endpackage

[hdl/lelt_if.sv]
// Valid/ready channel interfaces for input items and results.
interface lelt_in_if;
    logic                                   valid;
    logic                                   ready;
    logic        [lelt_pkg::KIND_W-1:0]     kind;
    logic signed [lelt_pkg::IN_W-1:0]       slope;
    logic signed [lelt_pkg::IN_W-1:0]       intercept;
    logic signed [lelt_pkg::IN_W-1:0]       point_x;

    modport source (output valid, kind, slope, intercept, point_x, input ready);
    modport sink   (input valid, kind, slope, intercept, point_x, output ready);
endinterface

interface lelt_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [lelt_pkg::VALUE_W-1:0]    value;
    logic        [lelt_pkg::STATUS_W-1:0]   status;
    logic        [lelt_pkg::LCOUNT_W-1:0]   line_count;

    modport source (output valid, value, status, line_count, input ready);
    modport sink   (input valid, value, status, line_count, output ready);
endinterface

[hdl/lelt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module lelt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/lower_envelope_line_table_core.sv]
// Lower envelope (convex hull trick) line table with monotone slopes.
//
// The block keeps lines y = slope*x + intercept in a circular double-ended store held
// in one RAM with a registered read port; slopes decrease from the front to the back.
// Each input beat gives exactly one result beat. Every line read goes through the single
// RAM read port and every evaluation or redundancy test goes through one shared 34x34
// multiplier, so the cost is set by those two resources. Clear, unused kinds and
// queries on an empty store go straight to the result; a search over n lines takes
// about ceil(log2 n) steps, each reading and evaluating two lines, plus a final
// evaluation; a monotone query makes one pop test per popped line plus one that keeps
// the end line, or ends with a final evaluation when it pops down to a single line; an
// add into an empty store is written at once, otherwise it checks the front line, then
// the back line when the line belongs at the back, runs its redundancy tests and then
// writes the line and returns (directly when fewer than two lines are left to test). A
// rejected or dropped add returns straight after its check. The pops are amortized over
// the adds. One item is worked on at a time; a new beat is taken while the previous
// result still waits in the output register, and the block waits in its output state
// while that result stays unaccepted and the next one is ready. The store needs no
// clearing after reset: only entries that hold a line are read.
// max_mode negates lines as they enter and query results as they leave.
module lower_envelope_line_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    lelt_in_if.sink     i_item,
    lelt_out_if.source  o_result
);

    typedef enum logic [12:0] {
        ST_IDLE    = 13'h0001,
        ST_LOOP    = 13'h0002,
        ST_RD_A    = 13'h0004,
        ST_RD_B    = 13'h0008,
        ST_RD_C    = 13'h0010,
        ST_ADD_CHK = 13'h0020,
        ST_DIFF    = 13'h0040,
        ST_MUL0    = 13'h0080,
        ST_MUL1    = 13'h0100,
        ST_DECIDE  = 13'h0200,
        ST_INSERT  = 13'h0400,
        ST_FIN     = 13'h0800,
        ST_OUT     = 13'h1000
    } t_state;

    // Control registers.
    t_state                                 r_state, n_state;
    logic [lelt_pkg::IDX_W-1:0]             r_head, n_head;
    logic [lelt_pkg::IDX_W-1:0]             r_tail, n_tail;
    logic [lelt_pkg::CNT_W-1:0]             r_count, n_count;
    logic [lelt_pkg::STATUS_W-1:0]          r_status, n_status;
    logic                                   r_out_valid, n_out_valid;
    logic                                   r_max;

    // Datapath registers.
    logic [lelt_pkg::KIND_W-1:0]            r_kind;
    logic signed [lelt_pkg::COEF_W-1:0]     r_s, r_c;
    logic signed [lelt_pkg::IN_W-1:0]       r_x;
    logic [lelt_pkg::IDX_W-1:0]             r_a0, r_a1;
    logic                                   r_two, r_final, r_back;
    logic signed [lelt_pkg::COEF_W-1:0]     r_l0s, r_l0i, r_l1s, r_l1i;
    logic signed [lelt_pkg::DIFF_W-1:0]     r_d0, r_d1, r_d2, r_d3;
    logic signed [lelt_pkg::PROD_W-1:0]     r_prod, r_p0;
    logic signed [lelt_pkg::VALUE_W-1:0]    r_e0, r_y;
    logic signed [lelt_pkg::SRCH_W-1:0]     r_lo, r_hi;
    logic signed [lelt_pkg::VALUE_W-1:0]    r_out_value;
    logic [lelt_pkg::STATUS_W-1:0]          r_out_status;
    logic [lelt_pkg::LCOUNT_W-1:0]          r_out_count;

    // Combinational helpers.
    logic                                   in_fire, out_free, is_add, is_query;
    logic                                   dominated, loop_two;
    logic signed [lelt_pkg::COEF_W-1:0]     in_s, in_c;
    logic signed [lelt_pkg::COEF_W-1:0]     sa, ia, sb, ib, sc, ic;
    logic signed [lelt_pkg::DIFF_W-1:0]     mul_a, mul_b;
    logic signed [lelt_pkg::VALUE_W-1:0]    e1;
    logic signed [lelt_pkg::SRCH_W:0]       srch_sum;
    logic signed [lelt_pkg::SRCH_W-1:0]     mid;
    logic [lelt_pkg::CNT_W-1:0]             cnt_m1, cnt_m2, loop_off0, loop_off1;
    logic                                   ram_we;
    logic [lelt_pkg::IDX_W-1:0]             ram_waddr, ram_raddr;
    logic [lelt_pkg::LINE_W-1:0]            ram_rdata;

    assign in_fire  = i_item.valid && i_item.ready;
    assign out_free = !r_out_valid || o_result.ready;
    assign is_add   = (r_kind == lelt_pkg::KIND_ADD);
    assign is_query = (i_item.kind == lelt_pkg::KIND_SEARCH) ||
                      (i_item.kind == lelt_pkg::KIND_INC) ||
                      (i_item.kind == lelt_pkg::KIND_DEC);

    // Incoming line, widened and negated for the upper envelope.
    always_comb begin
        in_s = lelt_pkg::COEF_W'(i_item.slope);
        in_c = lelt_pkg::COEF_W'(i_item.intercept);
        if (r_max) begin
            in_s = -in_s;
            in_c = -in_c;
        end
    end

    // Line store.
    assign ram_raddr = (r_state == ST_RD_B) ? r_a1 : r_a0;

    lelt_ram #(
        .WIDTH (lelt_pkg::LINE_W),
        .DEPTH (lelt_pkg::MAX_LINES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_s, r_c}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Three lines of a redundancy test, slopes decreasing from a to c.
    always_comb begin
        if (r_back) begin
            sa = r_l0s; ia = r_l0i; sb = r_l1s; ib = r_l1i; sc = r_s; ic = r_c;
        end else begin
            sa = r_s; ia = r_c; sb = r_l0s; ib = r_l0i; sc = r_l1s; ic = r_l1i;
        end
    end

    // Shared multiplier operands: differences for adds, slope times x for queries.
    always_comb begin
        if (is_add) begin
            mul_a = (r_state == ST_MUL1) ? r_d2 : r_d0;
            mul_b = (r_state == ST_MUL1) ? r_d3 : r_d1;
        end else begin
            mul_a = (r_state == ST_MUL1) ? lelt_pkg::DIFF_W'(r_l1s)
                                         : lelt_pkg::DIFF_W'(r_l0s);
            mul_b = lelt_pkg::DIFF_W'(r_x);
        end
    end

    // Pop or search decision from the two products.
    assign e1        = $signed(r_prod[lelt_pkg::VALUE_W-1:0]) + lelt_pkg::VALUE_W'(r_l1i);
    assign dominated = is_add ? (r_p0 >= r_prod) : (r_e0 >= e1);

    // Positions of the lines that the next step reads.
    assign srch_sum = (lelt_pkg::SRCH_W+1)'(r_lo) + (lelt_pkg::SRCH_W+1)'(r_hi);
    assign mid      = srch_sum[lelt_pkg::SRCH_W:1];
    assign cnt_m1   = r_count - 1'b1;
    assign cnt_m2   = r_count - 2'd2;

    always_comb begin
        loop_two  = 1'b0;
        loop_off0 = '0;
        loop_off1 = '0;
        case (r_kind)
            lelt_pkg::KIND_ADD: begin
                loop_two  = 1'b1;
                loop_off0 = r_back ? cnt_m2 : '0;
                loop_off1 = r_back ? cnt_m1 : lelt_pkg::CNT_W'(1);
            end
            lelt_pkg::KIND_INC: begin
                loop_two  = (r_count >= lelt_pkg::CNT_W'(2));
                loop_off1 = lelt_pkg::CNT_W'(1);
            end
            lelt_pkg::KIND_DEC: begin
                loop_two  = (r_count >= lelt_pkg::CNT_W'(2));
                loop_off0 = cnt_m1;
                loop_off1 = cnt_m2;
            end
            lelt_pkg::KIND_SEARCH: begin
                loop_two  = (r_lo + $signed(lelt_pkg::SRCH_W'(1))) < r_hi;
                loop_off0 = loop_two ? mid[lelt_pkg::CNT_W-1:0] : r_hi[lelt_pkg::CNT_W-1:0];
                loop_off1 = mid[lelt_pkg::CNT_W-1:0] + 1'b1;
            end
            default: begin
                loop_two = 1'b0;
            end
        endcase
    end

    // Sequencer and store pointers.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_status    = r_status;
        n_out_valid = r_out_valid && !o_result.ready;
        ram_we      = 1'b0;
        ram_waddr   = r_tail;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_status = (is_query && r_count == '0) ? lelt_pkg::STAT_EMPTY
                                                           : lelt_pkg::STAT_OK;
                    unique case (i_item.kind) inside
                        lelt_pkg::KIND_CLEAR: begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_count = '0;
                            n_state = ST_OUT;
                        end
                        lelt_pkg::KIND_ADD: begin
                            n_state = (r_count == '0) ? ST_INSERT : ST_RD_A;
                        end
                        lelt_pkg::KIND_SEARCH, lelt_pkg::KIND_INC, lelt_pkg::KIND_DEC: begin
                            n_state = (r_count == '0) ? ST_OUT : ST_LOOP;
                        end
                        default: begin
                            n_state = ST_OUT;
                        end
                    endcase
                end
            end
            ST_LOOP: begin
                n_state = (is_add && r_count < lelt_pkg::CNT_W'(2)) ? ST_INSERT : ST_RD_A;
            end
            ST_RD_A: begin
                n_state = ST_RD_B;
            end
            ST_RD_B: begin
                n_state = r_two ? ST_RD_C : (r_final ? ST_MUL0 : ST_ADD_CHK);
            end
            ST_RD_C: begin
                n_state = is_add ? ST_DIFF : ST_MUL0;
            end
            ST_DIFF: begin
                n_state = ST_MUL0;
            end
            ST_MUL0: begin
                n_state = r_final ? ST_FIN : ST_MUL1;
            end
            ST_MUL1: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_state = ST_LOOP;
                if (dominated) begin
                    if ((is_add && !r_back) || r_kind == lelt_pkg::KIND_INC) begin
                        n_head  = lelt_pkg::idx_inc(r_head);
                        n_count = r_count - 1'b1;
                    end else if (is_add || r_kind == lelt_pkg::KIND_DEC) begin
                        n_tail  = lelt_pkg::idx_dec(r_tail);
                        n_count = r_count - 1'b1;
                    end
                end else if (is_add) begin
                    // The end line stays: the new line goes in next to it.
                    n_state = ST_INSERT;
                end else if (r_kind != lelt_pkg::KIND_SEARCH) begin
                    // The end line stays and its value is already known.
                    n_state = ST_OUT;
                end
            end
            ST_ADD_CHK: begin
                if (!r_back && r_l0s > r_s) begin
                    // Not a front insert: look at the back line next.
                    n_state = ST_RD_A;
                end else if (r_back && r_s > r_l0s) begin
                    n_status = lelt_pkg::STAT_ORDER;
                    n_state  = ST_OUT;
                end else if (r_count >= lelt_pkg::CNT_W'(lelt_pkg::MAX_LINES)) begin
                    n_status = lelt_pkg::STAT_FULL;
                    n_state  = ST_OUT;
                end else if (r_l0s == r_s) begin
                    // Equal slope: keep the lower line only.
                    if (r_l0i <= r_c) begin
                        n_state = ST_OUT;
                    end else begin
                        n_count = r_count - 1'b1;
                        n_state = ST_LOOP;
                        if (r_back) begin
                            n_tail = lelt_pkg::idx_dec(r_tail);
                        end else begin
                            n_head = lelt_pkg::idx_inc(r_head);
                        end
                    end
                end else begin
                    n_state = ST_LOOP;
                end
            end
            ST_INSERT: begin
                ram_we  = 1'b1;
                n_count = r_count + 1'b1;
                n_state = ST_OUT;
                if (r_back) begin
                    ram_waddr = r_tail;
                    n_tail    = lelt_pkg::idx_inc(r_tail);
                end else begin
                    ram_waddr = lelt_pkg::idx_dec(r_head);
                    n_head    = lelt_pkg::idx_dec(r_head);
                    if (r_count == '0) begin
                        n_tail = r_head;
                    end
                end
            end
            ST_FIN: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state and the mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_status    <= lelt_pkg::STAT_OK;
            r_out_valid <= 1'b0;
            r_max       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
        end
    end

    // Datapath: operands, fetched lines, products and the result.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL0 || r_state == ST_MUL1) begin
            r_prod <= mul_a * mul_b;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_kind  <= i_item.kind;
                    r_x     <= i_item.point_x;
                    r_s     <= in_s;
                    r_c     <= in_c;
                    r_back  <= (r_count == '0);
                    r_a0    <= r_head;
                    r_two   <= 1'b0;
                    r_final <= 1'b0;
                    r_y     <= '0;
                    r_lo    <= '1;
                    r_hi    <= lelt_pkg::SRCH_W'(r_count) - 1'b1;
                end
            end
            ST_LOOP: begin
                r_a0    <= lelt_pkg::slot_idx(r_head, loop_off0);
                r_a1    <= lelt_pkg::slot_idx(r_head, loop_off1);
                r_two   <= loop_two;
                r_final <= !loop_two;
            end
            ST_RD_B: begin
                r_l0s <= $signed(ram_rdata[lelt_pkg::LINE_W-1:lelt_pkg::COEF_W]);
                r_l0i <= $signed(ram_rdata[lelt_pkg::COEF_W-1:0]);
            end
            ST_RD_C: begin
                r_l1s <= $signed(ram_rdata[lelt_pkg::LINE_W-1:lelt_pkg::COEF_W]);
                r_l1i <= $signed(ram_rdata[lelt_pkg::COEF_W-1:0]);
            end
            ST_ADD_CHK: begin
                if (!r_back && r_l0s > r_s) begin
                    r_back <= 1'b1;
                    r_a0   <= lelt_pkg::slot_idx(r_head, cnt_m1);
                end
            end
            ST_DIFF: begin
                r_d0 <= lelt_pkg::DIFF_W'(ib) - lelt_pkg::DIFF_W'(ia);
                r_d1 <= lelt_pkg::DIFF_W'(sb) - lelt_pkg::DIFF_W'(sc);
                r_d2 <= lelt_pkg::DIFF_W'(ic) - lelt_pkg::DIFF_W'(ib);
                r_d3 <= lelt_pkg::DIFF_W'(sa) - lelt_pkg::DIFF_W'(sb);
            end
            ST_MUL1: begin
                r_p0 <= r_prod;
                r_e0 <= $signed(r_prod[lelt_pkg::VALUE_W-1:0]) + lelt_pkg::VALUE_W'(r_l0i);
            end
            ST_DECIDE: begin
                if (r_kind == lelt_pkg::KIND_SEARCH) begin
                    if (dominated) begin
                        r_lo <= mid;
                    end else begin
                        r_hi <= mid;
                    end
                end else if (!dominated && !is_add) begin
                    r_y <= r_e0;
                end
            end
            ST_FIN: begin
                r_y <= $signed(r_prod[lelt_pkg::VALUE_W-1:0]) + lelt_pkg::VALUE_W'(r_l0i);
            end
            ST_OUT: begin
                if (out_free) begin
                    r_out_value  <= r_max ? -r_y : r_y;
                    r_out_status <= r_status;
                    r_out_count  <= lelt_pkg::LCOUNT_W'(r_count);
                end
            end
            default: begin
                r_two <= r_two;
            end
        endcase
    end

    assign i_item.ready        = (r_state == ST_IDLE);
    assign o_result.valid      = r_out_valid;
    assign o_result.value      = r_out_value;
    assign o_result.status     = r_out_status;
    assign o_result.line_count = r_out_count;

    // The tail always sits one past the last held line.
    a_tail_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail == lelt_pkg::slot_idx(r_head, r_count))
        else $error("tail pointer out of step with head and count");

    // The store never holds more lines than it has entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lelt_pkg::CNT_W'(lelt_pkg::MAX_LINES))
        else $error("line count above store depth");

    // A line is written only while a free entry remains.
    a_write_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_count < lelt_pkg::CNT_W'(lelt_pkg::MAX_LINES)))
        else $error("store write while full");

    // An accepted beat always starts work before the next beat can be taken.
    a_beat_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != ST_IDLE))
        else $error("accepted beat left the sequencer idle");

endmodule
